// ===== rtl/pbss_pkg.sv =====
// Shared types, constants and helpers for the pixel binning sum block.
package pbss_pkg;

    // Field and state widths
    localparam int PIX_W        = 16;
    localparam int ACC_W        = 19;
    localparam int STORE_W      = 22;
    localparam int ROW_W        = 3;
    localparam int LOG2_W       = 2;
    localparam int IMG_W        = 13;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;

    // Defaults for the top level parameters and fixed limits
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int MAX_BIN_LOG2  = 3;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [PIX_W-1:0]   PIX_MAX   = {PIX_W{1'b1}};
    localparam logic [STORE_W-1:0] STORE_MAX = {STORE_W{1'b1}};

    // Register reset values
    localparam logic [LOG2_W-1:0] BIN_X_RST = LOG2_W'(1);
    localparam logic [LOG2_W-1:0] BIN_Y_RST = LOG2_W'(1);
    localparam logic [IMG_W-1:0]  WIDTH_RST = IMG_W'(4096);

    // Register index, taken from paddr word offset
    typedef enum logic [1:0] {
        REG_BIN_X = 2'd0,
        REG_BIN_Y = 2'd1,
        REG_WIDTH = 2'd2
    } reg_idx_t;

    // Current configuration as seen by the front end
    typedef struct packed {
        logic [LOG2_W-1:0] bin_x_log2;
        logic [LOG2_W-1:0] bin_y_log2;
        logic [IMG_W-1:0]  image_width;
    } cfg_t;

    // One block-column command handed from front to back
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             first_row;
        logic             last_row;
        logic             row_end;
    } cmd_t;

    // Limit a log2 factor to the supported maximum
    function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
        logic [LOG2_W:0] lim;
        lim = (LOG2_W+1)'(MAX_BIN_LOG2);
        return ({1'b0, v} > lim) ? LOG2_W'(MAX_BIN_LOG2) : v;
    endfunction

    // Mask of the low bits that select a position inside a block
    function automatic logic [ROW_W-1:0] bin_mask(input logic [LOG2_W-1:0] l2);
        logic [ROW_W:0] one_hot;
        one_hot = (ROW_W+1)'(1) << l2;
        return ROW_W'(one_hot - (ROW_W+1)'(1));
    endfunction

endpackage

// ===== rtl/pbss_regs.sv =====
// APB configuration registers for the pixel binning sum block.
module pbss_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pbss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pbss_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output pbss_pkg::cfg_t                cfg
);
    import pbss_pkg::*;

    logic [LOG2_W-1:0] bin_x_reg;
    logic [LOG2_W-1:0] bin_y_reg;
    logic [IMG_W-1:0]  width_reg;
    logic              wr_en;
    reg_idx_t          sel_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign sel_idx = reg_idx_t'(paddr[3:2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_x_reg <= BIN_X_RST;
            bin_y_reg <= BIN_Y_RST;
            width_reg <= WIDTH_RST;
        end else if (wr_en) begin
            case (sel_idx)
                REG_BIN_X: bin_x_reg <= pwdata[LOG2_W-1:0];
                REG_BIN_Y: bin_y_reg <= pwdata[LOG2_W-1:0];
                REG_WIDTH: width_reg <= pwdata[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (sel_idx)
            REG_BIN_X: prdata = APB_DATA_W'(bin_x_reg);
            REG_BIN_Y: prdata = APB_DATA_W'(bin_y_reg);
            REG_WIDTH: prdata = APB_DATA_W'(width_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.bin_x_log2  = bin_x_reg;
    assign cfg.bin_y_log2  = bin_y_reg;
    assign cfg.image_width = width_reg;

endmodule

// ===== rtl/pbss_front.sv =====
// Front end: pixel counters, row accumulator and block-column command issue.
module pbss_front #(
    parameter int MAX_WIDTH = pbss_pkg::DEF_MAX_WIDTH,
    parameter int IDX_W     = $clog2(MAX_WIDTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pbss_pkg::cfg_t             cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [pbss_pkg::PIX_W-1:0] pixel,
    input  logic                       frame_start,
    input  logic                       queue_full,
    output logic                       push,
    output logic [IDX_W-1:0]           push_idx,
    output pbss_pkg::cmd_t             push_cmd
);
    import pbss_pkg::*;

    localparam int CMP_W = ((IDX_W > IMG_W) ? IDX_W : IMG_W) + 1;

    logic [IDX_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic             accept;
    logic [IDX_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [ACC_W-1:0] acc_old, acc_new;
    logic [LOG2_W-1:0] bx, by;
    logic [ROW_W-1:0] xmask, ymask, col_lo;
    logic [CMP_W-1:0] width_ext, width_eff, width_m1;
    logic             row_end, group_end, last_row;

    assign in_ready = !queue_full;
    assign accept   = in_valid & in_ready;

    // Effective factors and width
    always_comb begin
        bx        = clamp_log2(cfg.bin_x_log2);
        by        = clamp_log2(cfg.bin_y_log2);
        xmask     = bin_mask(bx);
        ymask     = bin_mask(by);
        width_ext = CMP_W'(cfg.image_width);
        if (width_ext == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        width_m1 = width_eff - CMP_W'(1);
    end

    // Classify the current pixel
    always_comb begin
        col       = frame_start ? '0 : col_reg;
        row       = frame_start ? '0 : row_reg;
        acc_old   = frame_start ? '0 : acc_reg;
        col_lo    = col[ROW_W-1:0] & xmask;
        row_end   = (CMP_W'(col) >= width_m1);
        group_end = (col_lo == xmask) || row_end;
        last_row  = (row >= ymask);
        acc_new   = (col_lo == '0) ? ACC_W'(pixel) : acc_old + ACC_W'(pixel);
    end

    // Next counter values
    always_comb begin
        acc_next = group_end ? '0 : acc_new;
        if (row_end) begin
            col_next = '0;
            row_next = last_row ? '0 : row + ROW_W'(1);
        end else begin
            col_next = col + IDX_W'(1);
            row_next = row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            acc_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
        end
    end

    // Command for the back end on the last pixel of a block row segment
    assign push               = accept & group_end;
    assign push_idx           = IDX_W'(col >> bx);
    assign push_cmd.acc       = acc_new;
    assign push_cmd.first_row = (row == '0);
    assign push_cmd.last_row  = last_row;
    assign push_cmd.row_end   = row_end;

endmodule

// ===== rtl/pbss_queue.sv =====
// Short command queue between the front and back ends.
module pbss_queue #(
    parameter int IDX_W = $clog2(pbss_pkg::DEF_MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [IDX_W-1:0] push_idx,
    input  pbss_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [IDX_W-1:0] head_idx,
    output pbss_pkg::cmd_t   head_cmd
);
    import pbss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [IDX_W-1:0] idx_q [QUEUE_DEPTH];
    cmd_t             cmd_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_idx = idx_q[rd_ptr_reg];
    assign head_cmd = cmd_q[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            idx_q[wr_ptr_reg] <= push_idx;
            cmd_q[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH)) else $error("queue fill level past depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("pop from empty queue");

    a_count_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (!push && !pop) |=> $stable(count_reg)) else $error("fill level moved while idle");

endmodule

// ===== rtl/pbss_back.sv =====
// Back end: line store read-modify-write, saturation and output register.
module pbss_back #(
    parameter int MAX_WIDTH = pbss_pkg::DEF_MAX_WIDTH,
    parameter int IDX_W     = $clog2(MAX_WIDTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  logic [IDX_W-1:0]           q_idx,
    input  pbss_pkg::cmd_t             q_cmd,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [pbss_pkg::PIX_W-1:0] out_value,
    output logic                       out_last
);
    import pbss_pkg::*;

    logic [STORE_W-1:0] line_mem [MAX_WIDTH];

    logic               advance;
    logic               b2_valid_reg;
    cmd_t               b2_cmd_reg;
    logic [IDX_W-1:0]   b2_idx_reg;
    logic [STORE_W-1:0] rd_data_reg;

    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_idx_reg;
    logic [STORE_W-1:0] fwd_data_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_value_reg;
    logic               out_last_reg;

    logic [STORE_W-1:0] base;
    logic [STORE_W:0]   sum;
    logic [STORE_W-1:0] total;
    logic               do_write, do_emit;

    // Whole back pipeline moves when the output register can take a beat
    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && !q_empty;

    // Combine the stored partial sum with this row's segment sum
    always_comb begin
        base  = (fwd_valid_reg && (fwd_idx_reg == b2_idx_reg)) ? fwd_data_reg : rd_data_reg;
        sum   = {1'b0, base} + (STORE_W+1)'(b2_cmd_reg.acc);
        if (b2_cmd_reg.first_row) begin
            total = STORE_W'(b2_cmd_reg.acc);
        end else if (sum[STORE_W]) begin
            total = STORE_MAX;
        end else begin
            total = sum[STORE_W-1:0];
        end
        do_write = b2_valid_reg && !b2_cmd_reg.last_row;
        do_emit  = b2_valid_reg && b2_cmd_reg.last_row;
    end

    // Line store: read for the head command, write back the stage result
    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_data_reg <= line_mem[q_idx];
            if (do_write) begin
                line_mem[b2_idx_reg] <= total;
            end
        end
    end

    // Stage payload and bypass of the write that raced the read
    always_ff @(posedge aclk) begin
        if (advance) begin
            b2_cmd_reg   <= q_cmd;
            b2_idx_reg   <= q_idx;
            fwd_idx_reg  <= b2_idx_reg;
            fwd_data_reg <= total;
        end
        if (advance && do_emit) begin
            out_value_reg <= (total > STORE_W'(PIX_MAX)) ? PIX_MAX : total[PIX_W-1:0];
            out_last_reg  <= b2_cmd_reg.row_end;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            b2_valid_reg  <= !q_empty;
            fwd_valid_reg <= do_write;
            out_valid_reg <= do_emit;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(b2_valid_reg) && $stable(rd_data_reg) && $stable(fwd_valid_reg))
        else $error("back stage moved during output stall");

    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(b2_valid_reg && b2_cmd_reg.last_row))
        else $error("result beat without a last-row command");

    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fwd_valid_reg) |-> $past(b2_valid_reg && !b2_cmd_reg.last_row))
        else $error("bypass armed without a store write");

endmodule

// ===== rtl/pixel_binning_sum_saturate_core.sv =====
// Top level of the pixel binning sum block with saturation.
//
// Accepts one 16-bit pixel per clock in raster order while s_tready is high and
// sums each block of 2^bin_x_log2 columns by 2^bin_y_log2 rows into one 16-bit
// result clamped at 65535, with tlast on the last result of an output row. The
// rate holds while m_tready keeps up: the front end counts and accumulates row
// segments, and the back end does one read-modify-write of the line store per
// cycle unless the output stalls (read data registered, the previous command's
// write bypassed on an address match). A result beat passes the queue, the b2
// stage and the output register after the pixel that closes its block. A
// four-entry command queue and a single output register decouple the two sides;
// s_tready drops only when the queue is full. The line store needs no clearing
// pass: entries are always written on a block's first row before any read.
module pixel_binning_sum_saturate_core #(
    parameter int MAX_WIDTH = pbss_pkg::DEF_MAX_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input pixels
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // [15:0] pixel
    input  logic [0:0]                      s_tuser,  // [0] frame_start
    // Binned results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // [15:0] binned_value
    output logic                            m_tlast,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pbss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pbss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pbss_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pbss_pkg::*;

    localparam int IDX_W = $clog2(MAX_WIDTH);

    cfg_t             cfg;
    logic             q_full, q_empty, q_push, q_pop;
    logic [IDX_W-1:0] push_idx, head_idx;
    cmd_t             push_cmd, head_cmd;

    pbss_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbss_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .IDX_W     (IDX_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pixel       (s_tdata),
        .frame_start (s_tuser[0]),
        .queue_full  (q_full),
        .push        (q_push),
        .push_idx    (push_idx),
        .push_cmd    (push_cmd)
    );

    pbss_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_idx (push_idx),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_idx (head_idx),
        .head_cmd (head_cmd)
    );

    pbss_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .IDX_W     (IDX_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_idx     (head_idx),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== bench/bin_sum_checker.sv =====
// Checker for the pixel binning core: predicts binned results and compares each output beat.
module bin_sum_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // [15:0] pixel
    input  logic [0:0]                      s_tuser,  // [0] frame_start
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,  // [15:0] binned_value
    input  logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pbss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pbss_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              pending_bins,
    output int                              error_count
);
    import pbss_pkg::*;

    localparam int LINE_DEPTH = DEF_MAX_WIDTH;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             line_end;
    } bin_result_t;

    // Shadow of the configuration registers
    logic [LOG2_W-1:0]  cfg_bx;
    logic [LOG2_W-1:0]  cfg_by;
    logic [IMG_W-1:0]   cfg_width;

    // Predicted binning state
    logic [11:0]        col_cnt;
    logic [ROW_W-1:0]   row_grp;
    logic [ACC_W-1:0]   row_sum;
    logic [STORE_W-1:0] line_sums [LINE_DEPTH];

    bin_result_t        expected_bins [$];
    int                 errors = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // Advance the predicted state by one pixel, queue a result if a block closes
    task automatic bin_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int              wid;
        int              xmask;
        int              ymask;
        int              col;
        int              idx;
        logic [STORE_W:0] total;
        logic            row_end;
        logic            grp_end;
        logic            last_row;
        bin_result_t     res;

        // width 0 acts as 1, anything past the line store as its full depth
        wid = (cfg_width == 0) ? 1 : (cfg_width > LINE_DEPTH) ? LINE_DEPTH : int'(cfg_width);
        // 2-bit factors never exceed the log2 limit of 3
        xmask = (1 << cfg_bx) - 1;
        ymask = (1 << cfg_by) - 1;

        if (fs) begin
            col_cnt = '0;
            row_grp = '0;
            row_sum = '0;
        end

        col      = int'(col_cnt);
        row_end  = (col >= wid - 1);
        grp_end  = ((col & xmask) == xmask) || row_end;
        last_row = (int'(row_grp) >= ymask);

        if ((col & xmask) == 0) begin
            row_sum = ACC_W'(pix);
        end else begin
            row_sum = row_sum + ACC_W'(pix);
        end

        if (grp_end) begin
            idx = (col >> cfg_bx) & (LINE_DEPTH - 1);
            if (row_grp == 0) begin
                total = (STORE_W+1)'(row_sum);
            end else begin
                total = (STORE_W+1)'(line_sums[idx]) + (STORE_W+1)'(row_sum);
                if (total > (STORE_W+1)'(STORE_MAX)) begin
                    total = (STORE_W+1)'(STORE_MAX);
                end
            end
            if (last_row) begin
                res.value    = (total > (STORE_W+1)'(PIX_MAX)) ? PIX_MAX : total[PIX_W-1:0];
                res.line_end = row_end;
                expected_bins.push_back(res);
            end else begin
                line_sums[idx] = total[STORE_W-1:0];
            end
            row_sum = '0;
        end

        if (row_end) begin
            col_cnt = '0;
            row_grp = last_row ? '0 : row_grp + ROW_W'(1);
        end else begin
            col_cnt = col_cnt + 12'd1;
        end
    endtask

    always @(posedge aclk) begin : monitor
        bin_result_t want;

        if (!aresetn) begin
            cfg_bx    = BIN_X_RST;
            cfg_by    = BIN_Y_RST;
            cfg_width = WIDTH_RST;
            col_cnt   = '0;
            row_grp   = '0;
            row_sum   = '0;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                line_sums[i] = '0;
            end
            expected_bins.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_BIN_X: cfg_bx    = pwdata[LOG2_W-1:0];
                    REG_BIN_Y: cfg_by    = pwdata[LOG2_W-1:0];
                    REG_WIDTH: cfg_width = pwdata[IMG_W-1:0];
                    default: ;
                endcase
            end

            // input beat
            if (s_tvalid && s_tready) begin
                bin_pixel(s_tdata, s_tuser[0]);
            end

            // output beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d last %0b", m_tdata, m_tlast));
                end else begin
                    want = expected_bins.pop_front();
                    if (m_tdata !== want.value) begin
                        report_mismatch($sformatf("binned_value %0d, expected %0d",
                                                  m_tdata, want.value));
                    end
                    if (m_tlast !== want.line_end) begin
                        report_mismatch($sformatf("line_end %0b, expected %0b",
                                                  m_tlast, want.line_end));
                    end
                end
            end
        end

        pending_bins <= expected_bins.size();
        error_count  <= errors;
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the pixel binning core: clock, reset, stimulus and verdict.
module tb_top;
    import pbss_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CALM_ITEMS   = 1700;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 5000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;  // [15:0] pixel
    logic [0:0]            s_tuser  = '0;  // [0] frame_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;        // [15:0] binned_value
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending_bins;
    int error_count;
    int pixels_sent = 0;
    int ready_hold  = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pixel_binning_sum_saturate_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bin_sum_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .pending_bins (pending_bins),
        .error_count  (error_count)
    );

    // Result side back-pressure: random stall bursts
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_tready <= !calm ? 1'b0 : 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(1, 5) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write all three registers back to back, then release the bus
    task automatic configure(input int bx, input int by, input int width);
        reg_idx_t    regs [3] = '{REG_BIN_X, REG_BIN_Y, REG_WIDTH};
        logic [31:0] vals [3];

        vals[0] = bx;
        vals[1] = by;
        vals[2] = width;
        for (int i = 0; i < 3; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[i], 2'b00};
            pwdata  <= vals[i];
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One pixel beat, with an occasional gap in front of it
    task automatic send_pixel(input logic [15:0] pix, input logic fs);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_bins != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          bx;
        int          by;
        int          width;
        int          eff;
        int          rows;
        int          n;
        int          mode;
        int          style;
        int          random_start;
        logic [15:0] pix;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain copy with 1 by 1 factors
        configure(0, 0, 3);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h5555, 1'b0);
        send_pixel(16'hAAAA, 1'b0);
        settle();

        // full-scale 2x2 block saturates
        configure(1, 1, 2);
        for (int i = 0; i < 4; i++) begin
            send_pixel(16'hFFFF, i == 0);
        end
        settle();

        // width 0 behaves as width 1
        configure(1, 0, 0);
        send_pixel(16'h1234, 1'b1);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h0001, 1'b0);
        settle();

        // width not a multiple of the factor: narrow last block
        configure(2, 0, 6);
        for (int i = 0; i < 6; i++) begin
            send_pixel(16'($urandom()), i == 0);
        end
        settle();

        // frame restart drops an unfinished block row
        configure(0, 1, 2);
        for (int i = 0; i < 6; i++) begin
            send_pixel(16'($urandom()), i == 0 || i == 2);
        end
        settle();

        // registers changed in mid frame: width shrinks past the column, then
        // the vertical factor drops below the row counter
        configure(0, 2, 4);
        for (int i = 0; i < 5; i++) begin
            send_pixel(16'($urandom()), i == 0);
        end
        settle();
        configure(0, 2, 1);
        send_pixel(16'($urandom()), 1'b0);
        settle();
        configure(0, 0, 1);
        send_pixel(16'($urandom()), 1'b0);
        settle();

        // Random frames; a frame that goes on without a restart keeps the
        // previous settings, so its later rows only read sums its own rows wrote
        bx    = 0;
        by    = 0;
        width = 1;
        random_start = pixels_sent;
        while (pixels_sent < random_start + RANDOM_ITEMS) begin
            // mode 7: extra rows that never finish a block, 8: continue the old
            // frame without a restart, 9: stray frame starts
            mode = $urandom_range(0, 9);
            if (mode != 8) begin
                bx = $urandom_range(0, 3);
                by = $urandom_range(0, 3);
                case ($urandom_range(0, 19))
                    0:       width = 0;
                    1:       width = 1;
                    2:       width = $urandom_range(4097, 8191);
                    3:       width = $urandom_range(41, 4096);
                    default: width = $urandom_range(1, 40);
                endcase
            end
            eff  = (width == 0) ? 1 : (width > 4096) ? 4096 : width;
            rows = (1 << by) * $urandom_range(1, 2);
            if (mode == 7 && by != 0) begin
                rows += $urandom_range(1, (1 << by) - 1);
            end
            n = eff * rows;
            if (n > 320) begin
                n = $urandom_range(16, 320);
            end
            style = $urandom_range(0, 3);

            if (mode != 8) begin
                configure(bx, by, width);
            end
            for (int i = 0; i < n; i++) begin
                case (style)
                    0:       pix = 16'($urandom());
                    1:       pix = 16'hFFFF - 16'($urandom_range(0, 3));
                    2:       pix = 16'($urandom_range(0, 255));
                    default: pix = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                endcase
                if (pixels_sent > random_start + CALM_ITEMS) begin
                    calm = 1'b1;
                end
                send_pixel(pix, (i == 0 && mode != 8) ||
                                (mode == 9 && $urandom_range(0, 15) == 0));
            end
            settle();
        end

        calm = 1'b1;
        settle();

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
